// ===== design/rgbab_pkg.sv =====
`timescale 1ns / 1ps
package rgbab_pkg;

  localparam int GLYPH_SIZE   = 32;
  localparam int GLYPH_HALF   = GLYPH_SIZE / 2;
  localparam int SCREEN_MAX   = 1024;
  localparam int SCREEN_RESET = 240;
  localparam int HALO_MIN     = 32;
  // floor(x / 5) == (x * 205) >> 10 for x below 1024
  localparam int DIV5_RECIP   = 205;
  localparam int DIV5_SHIFT   = 10;
  localparam int ADDR_W       = 5;

  localparam logic [2:0] REG_GLYPH_COLOR   = 3'd0;
  localparam logic [2:0] REG_HIGHLIGHT_ON  = 3'd1;
  localparam logic [2:0] REG_CENTER_X      = 3'd2;
  localparam logic [2:0] REG_CENTER_Y      = 3'd3;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;

  typedef struct packed {
    logic [15:0] glyph_color;
    logic        highlight_on;
    logic [11:0] center_x;
    logic [11:0] center_y;
    logic [10:0] screen_width;
    logic [10:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb8_t;

  // c * 255 / 31 == 8c + floor(7c / 31)
  function automatic logic [7:0] widen5(input logic [4:0] c);
    logic [2:0] k;
    k = 3'd0;
    if (c >= 5'd5)  k = 3'd1;
    if (c >= 5'd9)  k = 3'd2;
    if (c >= 5'd14) k = 3'd3;
    if (c >= 5'd18) k = 3'd4;
    if (c >= 5'd23) k = 3'd5;
    if (c >= 5'd27) k = 3'd6;
    if (c >= 5'd31) k = 3'd7;
    return {c, 3'b000} + {5'd0, k};
  endfunction

  // c * 255 / 63 == 4c + floor(c / 21)
  function automatic logic [7:0] widen6(input logic [5:0] c);
    logic [1:0] k;
    k = 2'd0;
    if (c >= 6'd21) k = 2'd1;
    if (c >= 6'd42) k = 2'd2;
    if (c >= 6'd63) k = 2'd3;
    return {c, 2'b00} + {6'd0, k};
  endfunction

  function automatic rgb8_t unpack565(input logic [15:0] p);
    rgb8_t c;
    c.r = widen5(p[15:11]);
    c.g = widen6(p[10:5]);
    c.b = widen5(p[4:0]);
    return c;
  endfunction

  function automatic logic [15:0] pack565(input rgb8_t c);
    return {c.r[7:3], c.g[7:2], c.b[7:3]};
  endfunction

endpackage

// ===== design/rgbab_regs.sv =====
`timescale 1ns / 1ps
module rgbab_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rgbab_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output rgbab_pkg::cfg_t             cfg
);

  rgbab_pkg::cfg_t cfg_r;

  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glyph_color   <= '0;
      cfg_r.highlight_on  <= 1'b0;
      cfg_r.center_x      <= '0;
      cfg_r.center_y      <= '0;
      cfg_r.screen_width  <= 11'(rgbab_pkg::SCREEN_RESET);
      cfg_r.screen_height <= 11'(rgbab_pkg::SCREEN_RESET);
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        rgbab_pkg::REG_GLYPH_COLOR:   cfg_r.glyph_color   <= pwdata[15:0];
        rgbab_pkg::REG_HIGHLIGHT_ON:  cfg_r.highlight_on  <= pwdata[0];
        rgbab_pkg::REG_CENTER_X:      cfg_r.center_x      <= pwdata[11:0];
        rgbab_pkg::REG_CENTER_Y:      cfg_r.center_y      <= pwdata[11:0];
        rgbab_pkg::REG_SCREEN_WIDTH:  cfg_r.screen_width  <= pwdata[10:0];
        rgbab_pkg::REG_SCREEN_HEIGHT: cfg_r.screen_height <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      rgbab_pkg::REG_GLYPH_COLOR:   prdata = {16'd0, cfg_r.glyph_color};
      rgbab_pkg::REG_HIGHLIGHT_ON:  prdata = {31'd0, cfg_r.highlight_on};
      rgbab_pkg::REG_CENTER_X:      prdata = {20'd0, cfg_r.center_x};
      rgbab_pkg::REG_CENTER_Y:      prdata = {20'd0, cfg_r.center_y};
      rgbab_pkg::REG_SCREEN_WIDTH:  prdata = {21'd0, cfg_r.screen_width};
      rgbab_pkg::REG_SCREEN_HEIGHT: prdata = {21'd0, cfg_r.screen_height};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/rgbab_geom.sv =====
`timescale 1ns / 1ps
// Screen clip (first stage) and framebuffer index multiply (second stage).
module rgbab_geom (
  input  logic            clk,
  input  rgbab_pkg::cfg_t cfg,
  input  logic [6:0]      in_offset_x,
  input  logic [6:0]      in_offset_y,
  output logic            inside_a,
  output logic [19:0]     index_b
);

  logic [12:0] px;
  logic [12:0] py;
  logic [10:0] sw_c;
  logic [10:0] sh_c;
  logic        in_glyph;
  logic        on_screen;
  logic [9:0]  px_r;
  logic [9:0]  py_r;
  logic        inside_r;
  logic [19:0] index_r;
  logic [20:0] row_base;

  assign sw_c = (cfg.screen_width > 11'(rgbab_pkg::SCREEN_MAX)) ?
                11'(rgbab_pkg::SCREEN_MAX) : cfg.screen_width;
  assign sh_c = (cfg.screen_height > 11'(rgbab_pkg::SCREEN_MAX)) ?
                11'(rgbab_pkg::SCREEN_MAX) : cfg.screen_height;

  // two's complement on 13 bits; bit 12 is the sign
  assign px = {cfg.center_x[11], cfg.center_x} + {6'd0, in_offset_x}
              - 13'(rgbab_pkg::GLYPH_HALF);
  assign py = {cfg.center_y[11], cfg.center_y} + {6'd0, in_offset_y}
              - 13'(rgbab_pkg::GLYPH_HALF);

  assign in_glyph  = ({1'b0, in_offset_x} < 8'(rgbab_pkg::GLYPH_SIZE)) &&
                     ({1'b0, in_offset_y} < 8'(rgbab_pkg::GLYPH_SIZE));
  assign on_screen = !px[12] && !py[12] &&
                     (px[11:0] < {1'b0, sw_c}) && (py[11:0] < {1'b0, sh_c});

  assign row_base = 21'(py_r) * 21'(sw_c);

  always_ff @(posedge clk) begin
    inside_r <= in_glyph && on_screen;
    px_r     <= px[9:0];
    py_r     <= py[9:0];
    index_r  <= row_base[19:0] + 20'(px_r);
  end

  assign inside_a = inside_r;
  assign index_b  = index_r;

endmodule

// ===== design/rgbab_mix.sv =====
`timescale 1ns / 1ps
// Two-stage channel mix: products, then (sum / 255) and RGB565 repack.
module rgbab_mix (
  input  logic               clk,
  input  rgbab_pkg::rgb8_t   fg,
  input  rgbab_pkg::rgb8_t   bg,
  input  logic [7:0]         wt,
  output logic [15:0]        pix
);

  logic [7:0]  f_ch [3];
  logic [7:0]  b_ch [3];
  logic [7:0]  wt_inv;
  logic [15:0] pf_r [3];
  logic [15:0] pb_r [3];
  logic [16:0] sum  [3];
  logic [16:0] adj  [3];
  rgbab_pkg::rgb8_t mixed;
  logic [15:0] pix_r;

  assign f_ch[0] = fg.r;
  assign f_ch[1] = fg.g;
  assign f_ch[2] = fg.b;
  assign b_ch[0] = bg.r;
  assign b_ch[1] = bg.g;
  assign b_ch[2] = bg.b;
  assign wt_inv  = 8'd255 - wt;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pf_r[i] <= 16'(f_ch[i]) * 16'(wt);
      pb_r[i] <= 16'(b_ch[i]) * 16'(wt_inv);
    end
  end

  // floor(s / 255) == (s + (s >> 8) + 1) >> 8 for s below 65535
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = 17'(pf_r[i]) + 17'(pb_r[i]);
      adj[i] = sum[i] + 17'(sum[i][15:8]) + 17'd1;
    end
    mixed.r = adj[0][15:8];
    mixed.g = adj[1][15:8];
    mixed.b = adj[2][15:8];
  end

  always_ff @(posedge clk) begin
    pix_r <= rgbab_pkg::pack565(mixed);
  end

  assign pix = pix_r;

endmodule

// ===== design/rgb565_alpha_glyph_blend.sv =====
`timescale 1ns / 1ps
// An accepted pixel passes stage registers A to E and the output register before out_valid.
// Throughput: one pixel per clock; busy is low except around reset.
// Depth is set by two blends, each a product stage and a divide/repack stage.
// Reset (rst_n low, synchronous): valid bits clear, config registers return to defaults,
// busy is registered and stays high through reset until it samples rst_n high. Results cannot stall.
module rgb565_alpha_glyph_blend (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [6:0]                   in_offset_x,
  input  logic [6:0]                   in_offset_y,
  input  logic [7:0]                   in_alpha,
  input  logic [15:0]                  in_background_pixel,
  output logic                         out_valid,
  output logic                         out_write_enable,
  output logic [19:0]                  out_pixel_index,
  output logic [15:0]                  out_pixel_value,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rgbab_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  rgbab_pkg::cfg_t  cfg;
  rgbab_pkg::rgb8_t fg_w;
  rgbab_pkg::rgb8_t halo_half;
  rgbab_pkg::rgb8_t halo_w;
  rgbab_pkg::rgb8_t pix1_w;
  logic             busy_r;
  logic             accept;
  logic             inside_a;
  logic [19:0]      index_b;
  logic [16:0]      hw_prod;
  logic [15:0]      pix1_c;
  logic [15:0]      pix2_e;

  // stage A
  logic             vld_a_r;
  logic [7:0]       alpha_a_r;
  rgbab_pkg::rgb8_t bgw_a_r;
  logic             hl_a_r;
  logic [7:0]       hw_a_r;
  // stage B
  logic             vld_b_r;
  logic             ok_b_r;
  logic             hl_b_r;
  logic [7:0]       hw_b_r;
  // stage C
  logic             vld_c_r;
  logic             ok_c_r;
  logic             hl_c_r;
  logic [7:0]       hw_c_r;
  logic [19:0]      idx_c_r;
  // stage D
  logic             vld_d_r;
  logic             ok_d_r;
  logic             hl_d_r;
  logic [19:0]      idx_d_r;
  logic [15:0]      pix1_d_r;
  // stage E
  logic             vld_e_r;
  logic             ok_e_r;
  logic             hl_e_r;
  logic [19:0]      idx_e_r;
  logic [15:0]      pix1_e_r;
  // output
  logic             out_valid_r;
  logic             out_we_r;
  logic [19:0]      out_idx_r;
  logic [15:0]      out_val_r;

  rgbab_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  rgbab_geom u_geom (
    .clk         (clk),
    .cfg         (cfg),
    .in_offset_x (in_offset_x),
    .in_offset_y (in_offset_y),
    .inside_a    (inside_a),
    .index_b     (index_b)
  );

  // halo weight floor(2a / 5)
  assign hw_prod = 17'({in_alpha, 1'b0}) * 17'(rgbab_pkg::DIV5_RECIP);

  // widened glyph color, half-intensity halo; user keeps config static in flight; unchecked
  assign fg_w        = rgbab_pkg::unpack565(cfg.glyph_color);
  assign halo_half.r = {1'b0, fg_w.r[7:1]};
  assign halo_half.g = {1'b0, fg_w.g[7:1]};
  assign halo_half.b = {1'b0, fg_w.b[7:1]};
  assign halo_w      = rgbab_pkg::unpack565(rgbab_pkg::pack565(halo_half));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r     <= 1'b0;
      vld_b_r     <= 1'b0;
      vld_c_r     <= 1'b0;
      vld_d_r     <= 1'b0;
      vld_e_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_a_r     <= accept;
      vld_b_r     <= vld_a_r;
      vld_c_r     <= vld_b_r;
      vld_d_r     <= vld_c_r;
      vld_e_r     <= vld_d_r;
      out_valid_r <= vld_e_r;
    end
  end

  always_ff @(posedge clk) begin
    alpha_a_r <= in_alpha;
    bgw_a_r   <= rgbab_pkg::unpack565(in_background_pixel);
    hl_a_r    <= cfg.highlight_on && (in_alpha > 8'(rgbab_pkg::HALO_MIN));
    hw_a_r    <= 8'(hw_prod >> rgbab_pkg::DIV5_SHIFT);

    ok_b_r    <= inside_a && (alpha_a_r != 8'd0);
    hl_b_r    <= hl_a_r;
    hw_b_r    <= hw_a_r;

    ok_c_r    <= ok_b_r;
    hl_c_r    <= hl_b_r;
    hw_c_r    <= hw_b_r;
    idx_c_r   <= index_b;

    ok_d_r    <= ok_c_r;
    hl_d_r    <= hl_c_r;
    idx_d_r   <= idx_c_r;
    pix1_d_r  <= pix1_c;

    ok_e_r    <= ok_d_r;
    hl_e_r    <= hl_d_r;
    idx_e_r   <= idx_d_r;
    pix1_e_r  <= pix1_d_r;

    out_we_r  <= ok_e_r;
    out_idx_r <= ok_e_r ? idx_e_r : 20'd0;
    out_val_r <= !ok_e_r ? 16'd0 : (hl_e_r ? pix2_e : pix1_e_r);
  end

  // glyph color over background, weight alpha (A -> C)
  rgbab_mix u_mix_main (
    .clk (clk),
    .fg  (fg_w),
    .bg  (bgw_a_r),
    .wt  (alpha_a_r),
    .pix (pix1_c)
  );

  assign pix1_w = rgbab_pkg::unpack565(pix1_c);

  // halo over the first result (C -> E)
  rgbab_mix u_mix_halo (
    .clk (clk),
    .fg  (halo_w),
    .bg  (pix1_w),
    .wt  (hw_c_r),
    .pix (pix2_e)
  );

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_pixel_index  = out_idx_r;
  assign out_pixel_value  = out_val_r;

endmodule

// ===== design/rgbab_chk.sv =====
`timescale 1ns / 1ps
module rgbab_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [7:0]  in_alpha,
  input logic        out_valid,
  input logic        out_write_enable,
  input logic [19:0] out_pixel_index,
  input logic [15:0] out_pixel_value
);

  // every accepted pixel gives one result on out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("result missing after accept");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 6))
    else $error("result without matching transfer");

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable) |-> (out_pixel_index == 20'd0 &&
                                          out_pixel_value == 16'd0))
    else $error("skipped pixel carries nonzero fields");

  a_alpha_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_write_enable) |-> ($past(in_alpha, 6) != 8'd0))
    else $error("transparent pixel marked for write");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy outside reset");

endmodule

bind rgb565_alpha_glyph_blend rgbab_chk u_rgbab_chk (.*);

// ===== tb/tb_rgb565_alpha_glyph_blend.sv =====
`timescale 1ns / 1ps
module tb_rgb565_alpha_glyph_blend;

  typedef struct {
    bit        we;
    bit [19:0] idx;
    bit [15:0] val;
  } pixel_write_t;

  class pixel_blend_scoreboard;
    bit [15:0]    fg_color;
    bit           halo_en;
    int           ctr_x;
    int           ctr_y;
    int           scr_w;
    int           scr_h;
    int           failures;
    pixel_write_t expected_writes[$];

    function new();
      fg_color = 16'd0;
      halo_en  = 1'b0;
      ctr_x    = 0;
      ctr_y    = 0;
      scr_w    = rgbab_pkg::SCREEN_RESET;
      scr_h    = rgbab_pkg::SCREEN_RESET;
      failures = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] v);
      case (idx)
        rgbab_pkg::REG_GLYPH_COLOR:   fg_color = v[15:0];
        rgbab_pkg::REG_HIGHLIGHT_ON:  halo_en  = v[0];
        rgbab_pkg::REG_CENTER_X:      ctr_x    = $signed(v[11:0]);
        rgbab_pkg::REG_CENTER_Y:      ctr_y    = $signed(v[11:0]);
        rgbab_pkg::REG_SCREEN_WIDTH:  scr_w    = v[10:0];
        rgbab_pkg::REG_SCREEN_HEIGHT: scr_h    = v[10:0];
        default: ;
      endcase
    endfunction

    function int expand5(bit [4:0] c);
      return int'(c) * 255 / 31;
    endfunction

    function int expand6(bit [5:0] c);
      return int'(c) * 255 / 63;
    endfunction

    function bit [15:0] pack_rgb(int r, int g, int b);
      bit [7:0] r8, g8, b8;
      r8 = r[7:0];
      g8 = g[7:0];
      b8 = b[7:0];
      return {r8[7:3], g8[7:2], b8[7:3]};
    endfunction

    function int mix_channel(int f, int b, int w);
      return (f * w + b * (255 - w)) / 255;
    endfunction

    function bit [15:0] blend_rgb565(bit [15:0] fg, bit [15:0] bg, int w);
      if (w == 0) return bg;
      if (w >= 255) return fg;
      return pack_rgb(mix_channel(expand5(fg[15:11]), expand5(bg[15:11]), w),
                      mix_channel(expand6(fg[10:5]), expand6(bg[10:5]), w),
                      mix_channel(expand5(fg[4:0]), expand5(bg[4:0]), w));
    endfunction

    function pixel_write_t predict_pixel(bit [6:0] ox, bit [6:0] oy, bit [7:0] a,
                                         bit [15:0] bg);
      pixel_write_t r;
      int           sw, sh, px, py, pos;
      bit [15:0]    v, halo;
      r  = '{0, 0, 0};
      sw = (scr_w > rgbab_pkg::SCREEN_MAX) ? rgbab_pkg::SCREEN_MAX : scr_w;
      sh = (scr_h > rgbab_pkg::SCREEN_MAX) ? rgbab_pkg::SCREEN_MAX : scr_h;
      px = ctr_x - rgbab_pkg::GLYPH_HALF + int'(ox);
      py = ctr_y - rgbab_pkg::GLYPH_HALF + int'(oy);
      if (ox >= rgbab_pkg::GLYPH_SIZE || oy >= rgbab_pkg::GLYPH_SIZE) return r;
      if (px < 0 || py < 0 || px >= sw || py >= sh || a == 0) return r;
      v = blend_rgb565(fg_color, bg, a);
      if (halo_en && a > rgbab_pkg::HALO_MIN) begin
        // halo is the glyph color at half intensity per widened channel
        halo = pack_rgb(expand5(fg_color[15:11]) >> 1, expand6(fg_color[10:5]) >> 1,
                        expand5(fg_color[4:0]) >> 1);
        v = blend_rgb565(halo, v, int'(a) * 2 / 5);
      end
      pos   = py * sw + px;
      r.we  = 1'b1;
      r.idx = pos[19:0];
      r.val = v;
      return r;
    endfunction

    function void note_pixel(bit [6:0] ox, bit [6:0] oy, bit [7:0] a, bit [15:0] bg);
      expected_writes.push_back(predict_pixel(ox, oy, a, bg));
    endfunction

    function void flag_error(string msg);
      if (failures < 10) $display("ERROR @%0t: %s", $time, msg);
      failures++;
    endfunction

    function void check_pixel(bit we, bit [19:0] idx, bit [15:0] val);
      pixel_write_t e;
      if (expected_writes.size() == 0) begin
        flag_error($sformatf("result with none pending: we=%0b idx=%0d val=%h",
                             we, idx, val));
        return;
      end
      e = expected_writes.pop_front();
      if (e.we !== we || e.idx !== idx || e.val !== val)
        flag_error($sformatf("exp we=%0b idx=%0d val=%h, got we=%0b idx=%0d val=%h",
                             e.we, e.idx, e.val, we, idx, val));
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [6:0]                   in_offset_x = '0;
  logic [6:0]                   in_offset_y = '0;
  logic [7:0]                   in_alpha = '0;
  logic [15:0]                  in_background_pixel = '0;
  logic                         out_valid;
  logic                         out_write_enable;
  logic [19:0]                  out_pixel_index;
  logic [15:0]                  out_pixel_value;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [rgbab_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  pixel_blend_scoreboard sb = new();
  bit                    no_gaps;

  rgb565_alpha_glyph_blend DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_offset_x         (in_offset_x),
    .in_offset_y         (in_offset_y),
    .in_alpha            (in_alpha),
    .in_background_pixel (in_background_pixel),
    .out_valid           (out_valid),
    .out_write_enable    (out_write_enable),
    .out_pixel_index     (out_pixel_index),
    .out_pixel_value     (out_pixel_value),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_pixel(out_write_enable, out_pixel_index, out_pixel_value);
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_glyph(logic [15:0] color, logic hl, int cx, int cy,
                               int sw, int sh);
    reg_write(rgbab_pkg::REG_GLYPH_COLOR, {16'd0, color});
    reg_write(rgbab_pkg::REG_HIGHLIGHT_ON, {31'd0, hl});
    reg_write(rgbab_pkg::REG_CENTER_X, cx);
    reg_write(rgbab_pkg::REG_CENTER_Y, cy);
    reg_write(rgbab_pkg::REG_SCREEN_WIDTH, sw);
    reg_write(rgbab_pkg::REG_SCREEN_HEIGHT, sh);
  endtask

  // start is left high after a transfer so back-to-back pixels need no toggle
  task automatic push_pixel(logic [6:0] ox, logic [6:0] oy, logic [7:0] a,
                            logic [15:0] bg);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start               <= 1'b1;
    in_offset_x         <= ox;
    in_offset_y         <= oy;
    in_alpha            <= a;
    in_background_pixel <= bg;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pixel(ox, oy, a, bg);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_pixel();
    logic [6:0] ox, oy;
    logic [7:0] a;
    ox = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 31));
    oy = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 31));
    case ($urandom_range(0, 7))
      0:       a = 8'd0;
      1:       a = 8'd255;
      2:       a = 8'($urandom_range(30, 35));
      default: a = 8'($urandom_range(0, 255));
    endcase
    push_pixel(ox, oy, a, 16'($urandom));
  endtask

  function automatic int pick_size(int k);
    case (k)
      0: return 1;
      1: return 1024;
      2: return 2047;
      3: return 0;
      4: return 1025;
      default: begin
        case ($urandom_range(0, 7))
          0:       return 1024;
          1:       return $urandom_range(1025, 2047);
          2:       return $urandom_range(1, 16);
          default: return $urandom_range(2, 1023);
        endcase
      end
    endcase
  endfunction

  task automatic random_phase(int k);
    int sw, sh, cx, cy, span_x, span_y;
    logic [15:0] color;
    sw     = pick_size(k);
    sh     = pick_size((k + 2) % 12);
    span_x = (sw > rgbab_pkg::SCREEN_MAX) ? rgbab_pkg::SCREEN_MAX : (sw == 0 ? 1 : sw);
    span_y = (sh > rgbab_pkg::SCREEN_MAX) ? rgbab_pkg::SCREEN_MAX : (sh == 0 ? 1 : sh);
    // keep the glyph mostly on screen so the blend path gets exercised
    cx = $urandom_range(0, span_x + 31) - 16;
    cy = $urandom_range(0, span_y + 31) - 16;
    if (k == 5) begin
      cx = -2048;
      cy = 2047;
    end else if (k == 6) begin
      cx = 2047;
      cy = -2048;
    end
    color = (k == 7) ? 16'hFFFF : (k == 8) ? 16'h0000 : 16'($urandom);
    program_glyph(color, k[0], cx, cy, sw, sh);
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (86) random_pixel();
    drain();
  endtask

  initial begin
    no_gaps = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: center at origin leaves only the lower-right quadrant on screen
    push_pixel(7'd0, 7'd0, 8'd255, 16'hFFFF);
    push_pixel(7'd16, 7'd16, 8'd128, 16'h1234);
    drain();

    program_glyph(16'hA5F3, 1'b1, 16, 16, 240, 240);
    push_pixel(7'd0, 7'd0, 8'd0, 16'hFFFF);
    push_pixel(7'd0, 7'd0, 8'd1, 16'h0000);
    push_pixel(7'd31, 7'd31, 8'd255, 16'hFFFF);
    push_pixel(7'd32, 7'd0, 8'd200, 16'h5555);
    push_pixel(7'd0, 7'd32, 8'd200, 16'hAAAA);
    push_pixel(7'd127, 7'd127, 8'd255, 16'hFFFF);
    push_pixel(7'd5, 7'd7, 8'd32, 16'hFFFF);
    push_pixel(7'd5, 7'd7, 8'd33, 16'h0000);
    push_pixel(7'd10, 7'd3, 8'd254, 16'hFFFF);
    push_pixel(7'd1, 7'd2, 8'd128, 16'h8410);
    push_pixel(7'd31, 7'd0, 8'd255, 16'h0000);
    push_pixel(7'd0, 7'd31, 8'd170, 16'hF800);
    push_pixel(7'd20, 7'd20, 8'd85, 16'h07E0);
    push_pixel(7'd12, 7'd30, 8'd64, 16'h001F);
    drain();

    program_glyph(16'hFFFF, 1'b0, 16, 16, 20, 20);
    push_pixel(7'd19, 7'd19, 8'd100, 16'h0000);
    push_pixel(7'd20, 7'd5, 8'd100, 16'h0000);
    push_pixel(7'd5, 7'd20, 8'd255, 16'hFFFF);
    push_pixel(7'd31, 7'd31, 8'd17, 16'h7BEF);
    drain();

    for (int k = 0; k < 12; k++) random_phase(k);

    repeat (12) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== rgb565_alpha_glyph_blend.f =====
design/rgbab_pkg.sv
design/rgbab_regs.sv
design/rgbab_geom.sv
design/rgbab_mix.sv
design/rgb565_alpha_glyph_blend.sv
design/rgbab_chk.sv
tb/tb_rgb565_alpha_glyph_blend.sv
